@@ sv/fbf_pkg.sv @@
package fbf_pkg;

	// Storage geometry
	localparam int DEPTH       = 4096;
	localparam int AW          = $clog2(DEPTH);
	localparam int PW          = AW + 1;
	localparam int CW          = $clog2(DEPTH + 1);

	// Request length handling
	localparam int MAX_REQUEST = 64;
	localparam int LW          = $clog2(MAX_REQUEST + 1);

	// Field widths fixed by the interface
	localparam int KIND_W      = 3;
	localparam int BYTE_W      = 8;
	localparam int REQ_W       = 7;
	localparam int CAP_W       = 13;
	localparam int FILL_W      = 13;
	localparam int TOT_W       = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	// Command queue between front and back
	localparam int QDEPTH      = 2;
	localparam int QPW         = $clog2(QDEPTH);
	localparam int QCW         = $clog2(QDEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 3'd0,
		KIND_READ  = 3'd1,
		KIND_PEEK  = 3'd2,
		KIND_POP   = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OP_STATUS,
		OP_WRITE,
		OP_BYTES
	} cmd_op_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill_level;
		logic [FILL_W-1:0] room_left;
		logic [TOT_W-1:0]  total_written;
		logic [TOT_W-1:0]  total_read;
		logic              ended;
		logic              at_eof;
	} status_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [AW-1:0]     addr;
		logic [BYTE_W-1:0] data;
		logic [LW-1:0]     count;
		logic              accepted;
		status_t           status;
	} cmd_t;

endpackage

@@ sv/fbf_channels.sv @@
interface fbf_in_if;
	logic                           valid;
	logic                           ready;
	logic [fbf_pkg::KIND_W-1:0]     kind;
	logic [fbf_pkg::BYTE_W-1:0]     data_byte;
	logic [fbf_pkg::REQ_W-1:0]      request_length;

	modport source (output valid, kind, data_byte, request_length, input ready);
	modport sink   (input valid, kind, data_byte, request_length, output ready);
endinterface

interface fbf_out_if;
	logic                           valid;
	logic                           ready;
	logic [fbf_pkg::BYTE_W-1:0]     out_byte;
	logic                           byte_valid;
	logic                           last;
	logic                           accepted;
	logic [fbf_pkg::FILL_W-1:0]     fill_level;
	logic [fbf_pkg::FILL_W-1:0]     room_left;
	logic [fbf_pkg::TOT_W-1:0]      total_written;
	logic [fbf_pkg::TOT_W-1:0]      total_read;
	logic                           ended;
	logic                           at_eof;

	modport source (output valid, out_byte, byte_valid, last, accepted, fill_level,
		room_left, total_written, total_read, ended, at_eof, input ready);
	modport sink   (input valid, out_byte, byte_valid, last, accepted, fill_level,
		room_left, total_written, total_read, ended, at_eof, output ready);
endinterface

interface fbf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fbf_pkg::CAP_W-1:0]      capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

@@ sv/fbf_front.sv @@
module fbf_front (
	input  logic            clk,
	input  logic            arst_n,
	fbf_in_if.sink          in_ch,
	fbf_cfg_if.sink         cfg_ch,
	input  logic            q_full,
	output logic            push,
	output fbf_pkg::cmd_t   cmd
);

	logic [fbf_pkg::CAP_W-1:0] capacity_q;
	logic [fbf_pkg::AW-1:0]    head_q, head_n;
	logic [fbf_pkg::CW-1:0]    held_q, held_n;
	logic [fbf_pkg::TOT_W-1:0] wt_q, wt_n, rt_q, rt_n;
	logic                      ended_q, ended_n;

	logic [fbf_pkg::CW-1:0]    eff_cap;
	logic [fbf_pkg::CW-1:0]    room;
	logic [fbf_pkg::LW-1:0]    len_c, n;
	logic [fbf_pkg::PW-1:0]    wr_sum, rd_sum;
	logic [fbf_pkg::AW-1:0]    wr_pos, rd_pos;

	// Handshakes: config always taken, items whenever the queue has room
	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !q_full;
	assign push         = in_ch.valid && in_ch.ready;

	// Classify the item and work out the bookkeeping after it
	always_comb begin
		if (32'(capacity_q) > 32'(fbf_pkg::DEPTH)) eff_cap = fbf_pkg::CW'(fbf_pkg::DEPTH);
		else eff_cap = fbf_pkg::CW'(capacity_q);

		if (32'(in_ch.request_length) > 32'(fbf_pkg::MAX_REQUEST))
			len_c = fbf_pkg::LW'(fbf_pkg::MAX_REQUEST);
		else
			len_c = fbf_pkg::LW'(in_ch.request_length);
		if (32'(len_c) > 32'(held_q)) n = fbf_pkg::LW'(held_q);
		else n = len_c;

		// tail slot for a write, new head after a removal
		wr_sum = fbf_pkg::PW'(head_q) + fbf_pkg::PW'(held_q);
		if (wr_sum >= fbf_pkg::PW'(fbf_pkg::DEPTH))
			wr_pos = fbf_pkg::AW'(wr_sum - fbf_pkg::PW'(fbf_pkg::DEPTH));
		else
			wr_pos = fbf_pkg::AW'(wr_sum);
		rd_sum = fbf_pkg::PW'(head_q) + fbf_pkg::PW'(n);
		if (rd_sum >= fbf_pkg::PW'(fbf_pkg::DEPTH))
			rd_pos = fbf_pkg::AW'(rd_sum - fbf_pkg::PW'(fbf_pkg::DEPTH));
		else
			rd_pos = fbf_pkg::AW'(rd_sum);

		head_n  = head_q;
		held_n  = held_q;
		wt_n    = wt_q;
		rt_n    = rt_q;
		ended_n = ended_q;

		cmd.op       = fbf_pkg::OP_STATUS;
		cmd.addr     = head_q;
		cmd.data     = in_ch.data_byte;
		cmd.count    = n;
		cmd.accepted = 1'b0;

		unique case (in_ch.kind)
			fbf_pkg::KIND_WRITE: begin
				if (held_q < eff_cap) begin
					held_n       = held_q + fbf_pkg::CW'(1);
					wt_n         = wt_q + 64'd1;
					cmd.op       = fbf_pkg::OP_WRITE;
					cmd.addr     = wr_pos;
					cmd.accepted = 1'b1;
				end
			end
			fbf_pkg::KIND_READ: begin
				head_n = rd_pos;
				held_n = held_q - fbf_pkg::CW'(n);
				rt_n   = rt_q + 64'(n);
				if (n != '0) cmd.op = fbf_pkg::OP_BYTES;
			end
			fbf_pkg::KIND_PEEK: begin
				if (n != '0) cmd.op = fbf_pkg::OP_BYTES;
			end
			fbf_pkg::KIND_POP: begin
				head_n = rd_pos;
				held_n = held_q - fbf_pkg::CW'(n);
				rt_n   = rt_q + 64'(n);
			end
			fbf_pkg::KIND_END: begin
				ended_n = 1'b1;
			end
			default: begin
			end
		endcase

		// status as it stands once the item is done
		room = (eff_cap > held_n) ? eff_cap - held_n : '0;
		cmd.status.fill_level    = fbf_pkg::FILL_W'(held_n);
		cmd.status.room_left     = fbf_pkg::FILL_W'(room);
		cmd.status.total_written = wt_n;
		cmd.status.total_read    = rt_n;
		cmd.status.ended         = ended_n;
		cmd.status.at_eof        = ended_n && (held_n == '0);
	end

	// Bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fbf_pkg::CAP_RESET;
			head_q     <= '0;
			held_q     <= '0;
			wt_q       <= '0;
			rt_q       <= '0;
			ended_q    <= 1'b0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) capacity_q <= cfg_ch.capacity;
			if (push) begin
				head_q  <= head_n;
				held_q  <= held_n;
				wt_q    <= wt_n;
				rt_q    <= rt_n;
				ended_q <= ended_n;
			end
		end
	end

endmodule

@@ sv/fbf_queue.sv @@
module fbf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fbf_pkg::cmd_t   push_data,
	input  logic            pop,
	output logic            full,
	output logic            valid,
	output fbf_pkg::cmd_t   head
);

	fbf_pkg::cmd_t           entries_q [fbf_pkg::QDEPTH];
	logic [fbf_pkg::QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [fbf_pkg::QCW-1:0] count_q;

	assign full  = (count_q == fbf_pkg::QCW'(fbf_pkg::QDEPTH));
	assign valid = (count_q != '0);
	assign head  = entries_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == fbf_pkg::QPW'(fbf_pkg::QDEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + fbf_pkg::QPW'(1);
			end
			if (pop) begin
				if (rd_ptr_q == fbf_pkg::QPW'(fbf_pkg::QDEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + fbf_pkg::QPW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + fbf_pkg::QCW'(1);
				2'b01:   count_q <= count_q - fbf_pkg::QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ sv/fbf_back.sv @@
module fbf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  fbf_pkg::cmd_t   head,
	output logic            pop,
	fbf_out_if.source       out_ch
);

	logic [fbf_pkg::BYTE_W-1:0] byte_store [fbf_pkg::DEPTH];

	logic [fbf_pkg::LW-1:0]     idx_q;
	logic                       valid_s1;
	logic                       byte_valid_s1, last_s1, accepted_s1;
	fbf_pkg::status_t           status_s1;
	logic [fbf_pkg::BYTE_W-1:0] rdata_s1;

	logic                       out_valid_q;
	logic [fbf_pkg::BYTE_W-1:0] out_byte_q;
	logic                       byte_valid_q, last_q, accepted_q;
	fbf_pkg::status_t           status_q;

	logic                       is_bytes, is_write, final_beat;
	logic                       out_free, s1_adv, s1_free, issue;
	logic [fbf_pkg::PW-1:0]     addr_sum;
	logic [fbf_pkg::AW-1:0]     rd_addr;

	// Issue control: one beat of the head command per cycle when the pipe can move
	always_comb begin
		is_bytes   = (head.op == fbf_pkg::OP_BYTES);
		is_write   = (head.op == fbf_pkg::OP_WRITE);
		final_beat = !is_bytes || (idx_q == head.count - fbf_pkg::LW'(1));

		addr_sum = fbf_pkg::PW'(head.addr) + fbf_pkg::PW'(idx_q);
		if (addr_sum >= fbf_pkg::PW'(fbf_pkg::DEPTH))
			rd_addr = fbf_pkg::AW'(addr_sum - fbf_pkg::PW'(fbf_pkg::DEPTH));
		else
			rd_addr = fbf_pkg::AW'(addr_sum);

		out_free = !out_valid_q || out_ch.ready;
		s1_adv   = valid_s1 && out_free;
		s1_free  = !valid_s1 || s1_adv;
		issue    = q_valid && s1_free;
		pop      = issue && final_beat;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (final_beat) idx_q <= '0;
				else idx_q <= idx_q + fbf_pkg::LW'(1);
			end
			if (issue) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Byte store: writes land in order ahead of any later read
	always_ff @(posedge clk) begin
		if (issue && is_write) byte_store[head.addr] <= head.data;
		if (issue && is_bytes) rdata_s1 <= byte_store[rd_addr];
	end

	// Result payload through the read stage and the output register
	always_ff @(posedge clk) begin
		if (issue) begin
			byte_valid_s1 <= is_bytes;
			last_s1       <= final_beat;
			accepted_s1   <= head.accepted;
			status_s1     <= head.status;
		end
		if (s1_adv) begin
			out_byte_q   <= byte_valid_s1 ? rdata_s1 : '0;
			byte_valid_q <= byte_valid_s1;
			last_q       <= last_s1;
			accepted_q   <= accepted_s1;
			status_q     <= status_s1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.byte_valid    = byte_valid_q;
	assign out_ch.last          = last_q;
	assign out_ch.accepted      = accepted_q;
	assign out_ch.fill_level    = status_q.fill_level;
	assign out_ch.room_left     = status_q.room_left;
	assign out_ch.total_written = status_q.total_written;
	assign out_ch.total_read    = status_q.total_read;
	assign out_ch.ended         = status_q.ended;
	assign out_ch.at_eof        = status_q.at_eof;

endmodule

@@ sv/flow_controlled_byte_fifo.sv @@
// A result beat passes from the command queue through the read stage and the output register.
// Throughput: one single-result item per cycle while the output is not stalled; a read or peek
// of n bytes holds the back end for n byte beats, one byte beat per cycle from the store port.
// Reset: pointers, counts, totals and ended flag clear, capacity returns to 4096;
// the byte store is not cleared and items are taken straight after reset.
module flow_controlled_byte_fifo (
	input  logic       clk,
	input  logic       arst_n,
	fbf_in_if.sink     in_ch,
	fbf_out_if.source  out_ch,
	fbf_cfg_if.sink    cfg_ch
);

	logic          q_full, q_valid, push, pop;
	fbf_pkg::cmd_t cmd, head;

	// Front: takes items, updates bookkeeping, issues commands
	fbf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg_ch (cfg_ch),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd)
	);

	// Command queue
	fbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (head)
	);

	// Back: store access and result beats
	fbf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

@@ tb/flow_controlled_byte_fifo_tb.sv @@
`timescale 1ns / 100ps

module flow_controlled_byte_fifo_tb;

	// Kinds the block ignores, answered with a plain status beat
	localparam logic [fbf_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [fbf_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	localparam logic [fbf_pkg::CAP_W-1:0] CAP_ABOVE_DEPTH = 13'h1FFF;
	localparam int REQ_MAX_FIELD = (1 << fbf_pkg::REQ_W) - 1;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 12;
	localparam int RANDOM_ITEMS = 70;
	localparam int PHASES       = 7;

	// One result beat as seen on the output channel
	typedef struct packed {
		logic [fbf_pkg::BYTE_W-1:0] out_byte;
		logic                       byte_valid;
		logic                       last;
		logic                       accepted;
		fbf_pkg::status_t           status;
	} beat_t;

	// Mirror of the FIFO state plus the beats still owed by the block
	class fifo_scoreboard;
		bit [fbf_pkg::BYTE_W-1:0] byte_copy [fbf_pkg::DEPTH];
		bit [fbf_pkg::AW-1:0]     head;
		bit [fbf_pkg::CW-1:0]     held;
		bit [fbf_pkg::TOT_W-1:0]  written;
		bit [fbf_pkg::TOT_W-1:0]  removed;
		bit                       ended_flag;
		bit [fbf_pkg::CAP_W-1:0]  capacity;
		beat_t                    due_beats [$];
		int                       errors;

		function new();
			capacity = fbf_pkg::CAP_RESET;
		endfunction

		function void set_capacity(bit [fbf_pkg::CAP_W-1:0] value);
			capacity = value;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		function int unsigned usable();
			return (32'(capacity) > fbf_pkg::DEPTH) ? fbf_pkg::DEPTH : 32'(capacity);
		endfunction

		// Status always reflects the state once the whole item is done
		function beat_t make_beat(logic [fbf_pkg::BYTE_W-1:0] b, logic bv, logic lst,
				logic acc);
			beat_t r;
			r.out_byte             = b;
			r.byte_valid           = bv;
			r.last                 = lst;
			r.accepted             = acc;
			r.status.fill_level    = fbf_pkg::FILL_W'(held);
			r.status.room_left     = (usable() > 32'(held)) ?
				fbf_pkg::FILL_W'(usable() - 32'(held)) : '0;
			r.status.total_written = written;
			r.status.total_read    = removed;
			r.status.ended         = ended_flag;
			r.status.at_eof        = ended_flag && (held == '0);
			return r;
		endfunction

		function void apply_command(logic [fbf_pkg::KIND_W-1:0] k,
				logic [fbf_pkg::BYTE_W-1:0] data, logic [fbf_pkg::REQ_W-1:0] len);
			bit [fbf_pkg::BYTE_W-1:0] taken [$];
			int unsigned              n;
			bit                       stored;
			stored = 1'b0;
			case (k)
				fbf_pkg::KIND_WRITE: begin
					if (32'(held) < usable()) begin
						byte_copy[fbf_pkg::AW'((32'(head) + 32'(held)) % fbf_pkg::DEPTH)] = data;
						held++;
						written++;
						stored = 1'b1;
					end
					due_beats.push_back(make_beat('0, 1'b0, 1'b1, stored));
				end
				fbf_pkg::KIND_END: begin
					ended_flag = 1'b1;
					due_beats.push_back(make_beat('0, 1'b0, 1'b1, 1'b0));
				end
				fbf_pkg::KIND_READ, fbf_pkg::KIND_PEEK, fbf_pkg::KIND_POP: begin
					// clamp to the request limit, then to what is held
					n = (32'(len) > fbf_pkg::MAX_REQUEST) ? fbf_pkg::MAX_REQUEST : 32'(len);
					if (n > 32'(held))
						n = 32'(held);
					for (int i = 0; i < n; i++)
						taken.push_back(byte_copy[fbf_pkg::AW'((32'(head) + 32'(i)) %
							fbf_pkg::DEPTH)]);
					if (k != fbf_pkg::KIND_PEEK) begin
						head    = fbf_pkg::AW'((32'(head) + n) % fbf_pkg::DEPTH);
						held    = fbf_pkg::CW'(32'(held) - n);
						removed = removed + fbf_pkg::TOT_W'(n);
					end
					if (k == fbf_pkg::KIND_POP || n == 0)
						due_beats.push_back(make_beat('0, 1'b0, 1'b1, 1'b0));
					else
						foreach (taken[i])
							due_beats.push_back(make_beat(taken[i], 1'b1, 32'(i) + 1 == n,
								1'b0));
				end
				default: begin
					due_beats.push_back(make_beat('0, 1'b0, 1'b1, 1'b0));
				end
			endcase
		endfunction

		function void compare(string field, logic [fbf_pkg::TOT_W-1:0] want,
				logic [fbf_pkg::TOT_W-1:0] seen);
			if (seen !== want) begin
				$display("%0t ns: %s expected %0h, got %0h", $time, field, want, seen);
				errors++;
			end
		endfunction

		function void check_beat(beat_t seen);
			beat_t want;
			if (due_beats.size() == 0) begin
				$display("%0t ns: stray beat, expected none, got %0h", $time, seen);
				errors++;
				return;
			end
			want = due_beats.pop_front();
			compare("out_byte", fbf_pkg::TOT_W'(want.out_byte),
				fbf_pkg::TOT_W'(seen.out_byte));
			compare("byte_valid", fbf_pkg::TOT_W'(want.byte_valid),
				fbf_pkg::TOT_W'(seen.byte_valid));
			compare("last", fbf_pkg::TOT_W'(want.last), fbf_pkg::TOT_W'(seen.last));
			compare("accepted", fbf_pkg::TOT_W'(want.accepted),
				fbf_pkg::TOT_W'(seen.accepted));
			compare("fill_level", fbf_pkg::TOT_W'(want.status.fill_level),
				fbf_pkg::TOT_W'(seen.status.fill_level));
			compare("room_left", fbf_pkg::TOT_W'(want.status.room_left),
				fbf_pkg::TOT_W'(seen.status.room_left));
			compare("total_written", want.status.total_written, seen.status.total_written);
			compare("total_read", want.status.total_read, seen.status.total_read);
			compare("ended", fbf_pkg::TOT_W'(want.status.ended),
				fbf_pkg::TOT_W'(seen.status.ended));
			compare("at_eof", fbf_pkg::TOT_W'(want.status.at_eof),
				fbf_pkg::TOT_W'(seen.status.at_eof));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fbf_in_if  in_if ();
	fbf_out_if out_if ();
	fbf_cfg_if cfg_if ();

	flow_controlled_byte_fifo DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg_ch (cfg_if)
	);

	fifo_scoreboard sb;
	bit             sender_gaps;
	bit             sink_stalls;
	bit             hold_off_req;
	int unsigned    cycle_no;
	int unsigned    last_move;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: give up when nothing has moved for too long
	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no - last_move > STALL_LIMIT) begin
				$display("flow_controlled_byte_fifo regression: fail");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin : sink_side
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_if.ready <= 1'b1;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_if.ready <= 1'b1;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// Result beats are sampled mid-cycle, where everything is settled
	initial begin : result_monitor
		beat_t seen;
		forever begin
			@(negedge clk);
			if (arst_n && out_if.valid && out_if.ready) begin
				seen.out_byte             = out_if.out_byte;
				seen.byte_valid           = out_if.byte_valid;
				seen.last                 = out_if.last;
				seen.accepted             = out_if.accepted;
				seen.status.fill_level    = out_if.fill_level;
				seen.status.room_left     = out_if.room_left;
				seen.status.total_written = out_if.total_written;
				seen.status.total_read    = out_if.total_read;
				seen.status.ended         = out_if.ended;
				seen.status.at_eof        = out_if.at_eof;
				sb.check_beat(seen);
				last_move = cycle_no;
			end
		end
	end

	// Offer one item; returns on the edge that takes the beat
	task automatic send_item(logic [fbf_pkg::KIND_W-1:0] k, logic [fbf_pkg::BYTE_W-1:0] b,
			logic [fbf_pkg::REQ_W-1:0] len);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_if.valid          <= 1'b1;
		in_if.kind           <= k;
		in_if.data_byte      <= b;
		in_if.request_length <= len;
		@(negedge clk);
		while (!in_if.ready) @(negedge clk);
		sb.apply_command(k, b, len);
		last_move = cycle_no;
		@(posedge clk);
	endtask

	// Stop offering and wait until every owed beat has come out
	task automatic halt_and_drain();
		in_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [fbf_pkg::CAP_W-1:0] value);
		cfg_if.valid    <= 1'b1;
		cfg_if.capacity <= value;
		@(negedge clk);
		while (!cfg_if.ready) @(negedge clk);
		sb.set_capacity(value);
		last_move = cycle_no;
		@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [fbf_pkg::KIND_W-1:0] pick_kind();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return fbf_pkg::KIND_WRITE;
		else if (roll < 64)
			return fbf_pkg::KIND_READ;
		else if (roll < 76)
			return fbf_pkg::KIND_PEEK;
		else if (roll < 90)
			return fbf_pkg::KIND_POP;
		else if (roll < 94)
			return fbf_pkg::KIND_END;
		return fbf_pkg::KIND_W'($urandom_range(32'(KIND_SPARE_LO), 32'(KIND_SPARE_HI)));
	endfunction

	// Mostly short requests, some up to the limit, a few beyond it
	function automatic logic [fbf_pkg::REQ_W-1:0] pick_length();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 16)
			return fbf_pkg::REQ_W'($urandom_range(0, 16));
		else if (roll < 19)
			return fbf_pkg::REQ_W'($urandom_range(17, fbf_pkg::MAX_REQUEST));
		return fbf_pkg::REQ_W'($urandom_range(fbf_pkg::MAX_REQUEST + 1, REQ_MAX_FIELD));
	endfunction

	initial begin : stimulus
		logic [fbf_pkg::CAP_W-1:0] caps [PHASES];
		sb = new();
		arst_n               = 1'b0;
		in_if.valid          <= 1'b0;
		in_if.kind           <= fbf_pkg::KIND_WRITE;
		in_if.data_byte      <= '0;
		in_if.request_length <= '0;
		cfg_if.valid         <= 1'b0;
		cfg_if.capacity      <= fbf_pkg::CAP_RESET;
		sender_gaps          = 1'b1;
		sink_stalls          = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests against an empty buffer
		send_item(fbf_pkg::KIND_READ, 8'h11, 7'd5);
		send_item(fbf_pkg::KIND_PEEK, 8'h22, 7'd0);
		send_item(fbf_pkg::KIND_POP, 8'h33, 7'd3);
		// Byte extremes, zero-length peek, over-long read
		send_item(fbf_pkg::KIND_WRITE, 8'h00, 7'd0);
		send_item(fbf_pkg::KIND_WRITE, 8'hFF, 7'd127);
		send_item(fbf_pkg::KIND_WRITE, 8'hA5, 7'd0);
		send_item(fbf_pkg::KIND_WRITE, 8'h5A, 7'd0);
		send_item(fbf_pkg::KIND_PEEK, 8'h00, 7'd0);
		send_item(fbf_pkg::KIND_PEEK, 8'h00, 7'd2);
		send_item(fbf_pkg::KIND_READ, 8'h00, 7'd127);
		send_item(fbf_pkg::KIND_WRITE, 8'h3C, 7'd0);
		send_item(fbf_pkg::KIND_WRITE, 8'hC3, 7'd0);
		send_item(fbf_pkg::KIND_POP, 8'h00, 7'd1);
		send_item(fbf_pkg::KIND_READ, 8'h00, 7'd64);
		send_item(KIND_SPARE_LO, 8'hFF, 7'd9);
		send_item(KIND_SPARE_HI, 8'h81, 7'd64);
		// Capacity pulled below the fill level: nothing lost, writes refused
		repeat (4) send_item(fbf_pkg::KIND_WRITE, fbf_pkg::BYTE_W'($urandom_range(0, 255)),
			7'd0);
		halt_and_drain();
		write_capacity(13'd2);
		send_item(fbf_pkg::KIND_WRITE, 8'h7E, 7'd0);
		send_item(fbf_pkg::KIND_POP, 8'h00, 7'd3);
		send_item(fbf_pkg::KIND_WRITE, 8'h42, 7'd0);
		send_item(fbf_pkg::KIND_WRITE, 8'h24, 7'd0);
		send_item(fbf_pkg::KIND_END, 8'h00, 7'd0);

		// Random phases over a spread of capacities; the last one runs flat out
		caps[0] = '0;
		caps[1] = 13'd1;
		caps[2] = 13'd2;
		caps[3] = fbf_pkg::CAP_W'($urandom_range(3, fbf_pkg::MAX_REQUEST));
		caps[4] = fbf_pkg::CAP_W'(fbf_pkg::DEPTH - 1);
		caps[5] = CAP_ABOVE_DEPTH;
		caps[6] = fbf_pkg::CAP_W'(fbf_pkg::DEPTH);
		for (int p = 0; p < PHASES; p++) begin
			halt_and_drain();
			write_capacity(caps[p]);
			sender_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			sink_stalls = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (p == 4)
				hold_off_req = 1'b1;
			repeat (RANDOM_ITEMS)
				send_item(pick_kind(), fbf_pkg::BYTE_W'($urandom_range(0, 255)),
					pick_length());
		end

		halt_and_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("flow_controlled_byte_fifo regression: pass");
		else
			$display("flow_controlled_byte_fifo regression: fail");
		$finish;
	end

endmodule
